// ===== rtl/f2i_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2i_pkg
// shared types and codes for the float to integer converter
// ----------------------------------------------------------------------------
package f2i_pkg;

  typedef enum logic [1:0] {
    RM_RNE = 2'd0,
    RM_RTZ = 2'd1,
    RM_RUP = 2'd2,
    RM_RDN = 2'd3
  } rmode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_NAN   = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [63:0] operand_bits;
    logic        is_double;
    logic        to_long;
    logic [1:0]  cmd;
    logic        saturate;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic [1:0]         status;
  } out_item_t;

  // unpacked operand after the front end
  typedef struct packed {
    logic        is_nan;
    logic        is_inf;
    logic        neg;
    logic [52:0] sig;
    logic [11:0] e;        // signed unbiased exponent of sig lsb
    logic        to_long;
    logic [1:0]  cmd;
    logic        saturate;
  } unpk_t;

endpackage

// ===== rtl/f2i_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2i_if
// valid/ready channel carrying one item per transfer
// ----------------------------------------------------------------------------
interface f2i_in_if;
  logic                valid;
  logic                ready;
  f2i_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface f2i_out_if;
  logic                valid;
  logic                ready;
  f2i_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/f2i_unpack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2i_unpack
// splits single or double bits into sign, significand and exponent
// ----------------------------------------------------------------------------
module f2i_unpack (
  input  f2i_pkg::in_item_t item,
  output f2i_pkg::unpk_t    unpk
);
  logic [10:0] expf;
  logic [51:0] mant;
  logic        emax;
  logic        ezero;

  always_comb begin
    if (item.is_double) begin
      expf = item.operand_bits[62:52];
      mant = item.operand_bits[51:0];
      emax = (expf == 11'h7FF);
    end else begin
      expf = {3'd0, item.operand_bits[30:23]};
      mant = {29'd0, item.operand_bits[22:0]};
      emax = (expf == 11'h0FF);
    end
    ezero = (expf == 11'd0);
    unpk.neg = item.is_double ? item.operand_bits[63] : item.operand_bits[31];
    unpk.is_nan = emax && (mant != 52'd0);
    unpk.is_inf = emax && (mant == 52'd0);
    if (item.is_double) begin
      unpk.sig = {~ezero, mant};
      unpk.e   = (ezero ? 12'sd1 : $signed({1'b0, expf})) - 12'sd1075;
    end else begin
      unpk.sig = {29'd0, ~ezero, mant[22:0]};
      unpk.e   = (ezero ? 12'sd1 : $signed({1'b0, expf})) - 12'sd150;
    end
    unpk.to_long  = item.to_long;
    unpk.cmd      = item.cmd;
    unpk.saturate = item.saturate;
  end
endmodule

// ===== rtl/f2i_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2i_round
// aligns the significand, rounds, range checks and saturates
// ----------------------------------------------------------------------------
module f2i_round (
  input  f2i_pkg::unpk_t     unpk,
  output f2i_pkg::out_item_t res
);
  logic [116:0] shl;
  logic [52:0]  ip;
  logic         rb;
  logic         st;
  logic         over;
  logic         inc;
  logic [64:0]  mag;
  logic [64:0]  lim;
  logic [63:0]  maxpos;
  logic [63:0]  minneg;
  logic [5:0]   s;
  logic [53:0]  low;
  logic [6:0]   rs;

  always_comb begin
    maxpos = unpk.to_long ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h0000_0000_7FFF_FFFF;
    minneg = unpk.to_long ? 64'h8000_0000_0000_0000 : 64'hFFFF_FFFF_8000_0000;
    over = 1'b0;
    ip = '0; rb = 1'b0; st = 1'b0; inc = 1'b0;
    shl = '0; s = '0; low = '0; rs = '0;
    mag = '0;
    if (unpk.is_inf) begin
      over = 1'b1;
    end else if (!unpk.e[11]) begin
      // left shift, exponent at most 971
      if (unpk.sig == 53'd0) begin
        mag = '0;
      end else if (unpk.e >= 12'd64) begin
        over = 1'b1;
      end else begin
        s   = unpk.e[5:0];
        shl = {64'd0, unpk.sig} << s;
        over = (shl[116:64] != 53'd0);
        mag = {1'b0, shl[63:0]};
      end
    end else begin
      // right shift; sig fits 53 bits so shifts past 53 leave only sticky
      if ($signed(unpk.e) < -12'sd53) begin
        st = (unpk.sig != 53'd0);
      end else begin
        rs  = 7'(-$signed(unpk.e));
        ip  = unpk.sig >> rs;
        low = {unpk.sig, 1'b0} << (7'd53 - rs);
        rb  = low[53];
        st  = (low[52:0] != 53'd0);
      end
      unique case (f2i_pkg::rmode_t'(unpk.cmd))
        f2i_pkg::RM_RNE: inc = rb && (st || ip[0]);
        f2i_pkg::RM_RTZ: inc = 1'b0;
        f2i_pkg::RM_RUP: inc = !unpk.neg && (rb || st);
        f2i_pkg::RM_RDN: inc = unpk.neg && (rb || st);
        default:         inc = 1'b0;
      endcase
      mag = {12'd0, ip} + {64'd0, inc};
    end
    lim = unpk.neg ? {1'b0, 64'd0 - minneg} : {1'b0, maxpos};
    if (unpk.is_nan) begin
      res.status = f2i_pkg::ST_NAN;
      res.result = unpk.saturate ? 64'd0 : minneg;
    end else if (over || mag > lim) begin
      res.status = f2i_pkg::ST_RANGE;
      res.result = (unpk.saturate && !unpk.neg) ? maxpos : minneg;
    end else begin
      res.status = f2i_pkg::ST_OK;
      res.result = unpk.neg ? 64'd0 - mag[63:0] : mag[63:0];
    end
  end
endmodule

// ===== rtl/float_to_int_rounding_converter_core.sv =====
`timescale 1ns / 1ps
// each item passes through the input register and then the result register
// throughput: one item per cycle while the result side keeps ready high
// a held result stalls the input only when the input stage is also full
// reset: synchronous active-low rst_n clears both valid flags
// ----------------------------------------------------------------------------
// float_to_int_rounding_converter_core
// ieee single/double to signed 32/64-bit integer with four rounding modes
// ----------------------------------------------------------------------------
module float_to_int_rounding_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  f2i_in_if.sink      in_ch,
  f2i_out_if.source   out_ch
);
  // input register stage
  f2i_pkg::in_item_t  in_r;
  logic               in_vld_r;
  // result register stage
  f2i_pkg::out_item_t out_r;
  logic               out_vld_r;

  f2i_pkg::unpk_t     unpk;
  f2i_pkg::out_item_t res_nxt;
  logic               adv;

  // result stage takes a new value when empty or being drained
  assign adv          = !out_vld_r || out_ch.ready;
  // input stage can take a transfer when it is empty or empties into the result stage
  assign in_ch.ready  = !in_vld_r || adv;

  f2i_unpack u_unpack (
    .item (in_r),
    .unpk (unpk)
  );

  f2i_round u_round (
    .unpk (unpk),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_r <= in_ch.data;
    end
    if (adv && in_vld_r) begin
      out_r <= res_nxt;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;
endmodule
